@@ src/bitmap_frame_allocator_defines.svh @@
// Assertion macros shared by the frame allocator checker
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bfa_pkg.sv @@
// Shared types and codes for the bitmap frame allocator
package bfa_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W = 13;
  localparam logic [ADDR_W-1:0] MARK_ALIGN_MASK = 32'h0000_03FF;

  typedef enum logic [2:0] {
    CMD_ALLOC_ONE = 3'd0,
    CMD_ALLOC_RUN = 3'd1,
    CMD_FREE_RUN  = 3'd2,
    CMD_MARK_USED = 3'd3,
    CMD_PREFETCH  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OUT_OF_MEM   = 3'd1,
    ST_OUT_OF_RANGE = 3'd2,
    ST_MISALIGNED   = 3'd3,
    ST_DOUBLE_FREE  = 3'd4,
    ST_BAD_COUNT    = 3'd5
  } status_t;

  typedef enum logic {
    REG_BASE_ADDRESS  = 1'b0,
    REG_FRAMES_IN_USE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] end_address;
    logic [CNT_W-1:0]  count;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              applied;
    logic [ADDR_W-1:0] frame_address;
    logic [CNT_W-1:0]  used_frames;
  } out_t;

endpackage

@@ src/bitmap_frame_allocator.sv @@
// Bitmap frame allocator top level: command sequencer over a serial map scan.
// After reset a clearing pass writes one map bit per cycle, covering all MAX_FRAMES bits.
// An alloc_one served from the queue and a rejected command go from accept straight to
// the result. A refill, run search, free or mark scans the map, reading one map bit per
// cycle, then finishes; a run allocation then sets the found run before the result.
// One command at a time; the next is taken after the result transaction.
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_FRAMES  = 4096,
  parameter int unsigned CACHE_DEPTH = 16,
  parameter int unsigned FRAME_SHIFT = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam int unsigned IW = $clog2(MAX_FRAMES);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned CW = (LW > CNT_W) ? LW : CNT_W;
  localparam int unsigned QW = $clog2(CACHE_DEPTH + 1);
  localparam int unsigned QI = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_WRITE = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    K_REFILL = 2'd0,
    K_RUN    = 2'd1,
    K_FREE   = 2'd2,
    K_MARK   = 2'd3
  } kind_t;

  state_t state, state_next;
  kind_t  kind, kind_next;

  logic [ADDR_W-1:0] base_address;
  logic [CNT_W-1:0]  frames_in_use;
  logic [IW-1:0]     queue [CACHE_DEPTH];
  logic [QW-1:0]     qfill, qfill_next, qnext, qnext_next;
  logic [QW-1:0]     got, got_next, need, need_next;
  logic [LW-1:0]     used, used_next;
  logic [LW-1:0]     ptr, ptr_next, end_ptr, end_ptr_next;
  logic [LW-1:0]     pidx, pidx_next, start, start_next;
  logic              pend, pend_next, serve, serve_next;
  logic              found, found_next, first, first_next;
  logic [CNT_W-1:0]  run, run_next, cnt, cnt_next;
  logic [CW-1:0]     addn, addn_next;
  out_t              res, res_next;
  logic [LW-1:0]     lim;

  logic          rd_en, rd_data, wr_en, wr_bit, q_we;
  logic [IW-1:0] rd_addr, wr_addr;

  bfa_bitmap #(
    .DEPTH (MAX_FRAMES),
    .AW    (IW)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_bit  (wr_bit)
  );

  function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] u, input logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(u) + (CW+1)'(n);
    return (s > (CW+1)'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : LW'(s);
  endfunction

  function automatic logic [LW-1:0] sat_sub(input logic [LW-1:0] u, input logic [CNT_W-1:0] n);
    return (CW'(n) > CW'(u)) ? '0 : LW'(CW'(u) - CW'(n));
  endfunction

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [ADDR_W-1:0] b,
                                                   input logic [IW-1:0] idx);
    return b + (ADDR_W'(idx) << FRAME_SHIFT);
  endfunction

  // Clamp the managed frame count to the map size
  assign lim = (CW'(frames_in_use) > CW'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : LW'(frames_in_use);

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= '0;
      frames_in_use <= CNT_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE_ADDRESS:  base_address  <= cfg_data;
        REG_FRAMES_IN_USE: frames_in_use <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    logic [ADDR_W-1:0] sidx, eidx;
    logic [ADDR_W:0]   fend;
    logic [2:0]        c;
    state_next = state;
    kind_next  = kind;
    qfill_next = qfill;
    qnext_next = qnext;
    got_next   = got;
    need_next  = need;
    used_next  = used;
    ptr_next   = ptr;
    end_ptr_next = end_ptr;
    pidx_next  = pidx;
    start_next = start;
    pend_next  = pend;
    serve_next = serve;
    found_next = found;
    first_next = first;
    run_next   = run;
    cnt_next   = cnt;
    addn_next  = addn;
    res_next   = res;
    rd_en   = 1'b0;
    rd_addr = ptr[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = pidx[IW-1:0];
    wr_bit  = 1'b0;
    q_we    = 1'b0;
    sidx = (in_data.address - base_address) >> FRAME_SHIFT;
    eidx = (in_data.end_address - base_address) >> FRAME_SHIFT;
    fend = (ADDR_W+1)'(sidx) + (ADDR_W+1)'(in_data.count);
    c = in_data.cmd;
    if (c == CMD_ALLOC_RUN && in_data.count == CNT_W'(1)) begin
      c = CMD_ALLOC_ONE;
    end

    case (state)
      S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = ptr[IW-1:0];
        ptr_next = ptr + LW'(1);
        if (ptr == LW'(MAX_FRAMES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          res_next = '{status: ST_OK, applied: 1'b0, frame_address: '0, used_frames: '0};
          state_next = S_OUT;
          ptr_next   = '0;
          end_ptr_next = lim;
          pend_next  = 1'b0;
          got_next   = '0;
          cnt_next   = in_data.count;
          case (c)
            CMD_ALLOC_ONE: begin
              if (qnext < qfill) begin
                res_next.frame_address = frame_addr(base_address, queue[qnext[QI-1:0]]);
                qnext_next = qnext + QW'(1);
                used_next  = sat_add(used, CW'(1));
              end else begin
                kind_next  = K_REFILL;
                serve_next = 1'b1;
                need_next  = QW'(CACHE_DEPTH);
                state_next = S_SCAN;
              end
            end
            CMD_ALLOC_RUN: begin
              if (in_data.count == '0) begin
                res_next.status = ST_BAD_COUNT;
              end else begin
                kind_next  = K_RUN;
                run_next   = '0;
                found_next = 1'b0;
                state_next = S_SCAN;
              end
            end
            CMD_FREE_RUN: begin
              if (in_data.count == '0) begin
                res_next.status = ST_BAD_COUNT;
              end else if (fend > (ADDR_W+1)'(lim)) begin
                res_next.status = ST_OUT_OF_RANGE;
              end else begin
                if ((in_data.address & ((ADDR_W'(1) << FRAME_SHIFT) - ADDR_W'(1))) != '0) begin
                  res_next.status = ST_MISALIGNED;
                end
                kind_next    = K_FREE;
                first_next   = 1'b1;
                ptr_next     = LW'(sidx);
                end_ptr_next = LW'(fend);
                state_next   = S_SCAN;
              end
            end
            CMD_MARK_USED: begin
              if (((in_data.address | in_data.end_address) & MARK_ALIGN_MASK) != '0) begin
                res_next.status = ST_MISALIGNED;
              end else if (eidx >= ADDR_W'(lim)) begin
                res_next.status = ST_OUT_OF_RANGE;
              end else if (sidx <= eidx) begin
                kind_next    = K_MARK;
                ptr_next     = LW'(sidx);
                end_ptr_next = LW'(eidx) + LW'(1);
                addn_next    = CW'(eidx - sidx) + CW'(1);
                state_next   = S_SCAN;
              end
            end
            CMD_PREFETCH: begin
              if (in_data.count == '0) begin
                res_next.status = ST_BAD_COUNT;
              end else begin
                kind_next  = K_REFILL;
                serve_next = 1'b0;
                need_next  = (CW'(in_data.count) > CW'(CACHE_DEPTH)) ?
                             QW'(CACHE_DEPTH) : QW'(in_data.count);
                state_next = S_SCAN;
              end
            end
            default: res_next.status = ST_OUT_OF_RANGE;
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read, one bit ahead of the processed one
        if (ptr < end_ptr) begin
          rd_en     = 1'b1;
          ptr_next  = ptr + LW'(1);
          pend_next = 1'b1;
          pidx_next = ptr;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = S_FIN;
          end
        end
        // Process the bit read last cycle
        if (pend) begin
          case (kind)
            K_REFILL: begin
              if (!rd_data) begin
                wr_en    = 1'b1;
                wr_bit   = 1'b1;
                q_we     = 1'b1;
                got_next = got + QW'(1);
                if (got + QW'(1) == need) begin
                  state_next = S_FIN;
                end
              end
            end
            K_RUN: begin
              run_next = rd_data ? '0 : run + CNT_W'(1);
              if (!rd_data && (run + CNT_W'(1) == cnt)) begin
                found_next = 1'b1;
                start_next = LW'(CW'(pidx) + CW'(1) - CW'(cnt));
                state_next = S_FIN;
              end
            end
            K_FREE: begin
              wr_en      = 1'b1;
              first_next = 1'b0;
              if (rd_data) begin
                res_next.applied = 1'b1;
              end else if (first && res.status == ST_OK) begin
                res_next.status = ST_DOUBLE_FREE;
              end
            end
            K_MARK: begin
              wr_en  = 1'b1;
              wr_bit = 1'b1;
              if (!rd_data) begin
                res_next.applied = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      S_FIN: begin
        state_next = S_OUT;
        case (kind)
          K_REFILL: begin
            qfill_next = got;
            qnext_next = '0;
            if (got == '0) begin
              res_next.status = ST_OUT_OF_MEM;
            end else begin
              res_next.applied = 1'b1;
              if (serve) begin
                res_next.frame_address = frame_addr(base_address, queue[0]);
                qnext_next = QW'(1);
                used_next  = sat_add(used, CW'(1));
              end
            end
          end
          K_RUN: begin
            if (!found) begin
              res_next.status = ST_OUT_OF_MEM;
            end else begin
              res_next.applied = 1'b1;
              ptr_next     = start;
              end_ptr_next = LW'(CW'(start) + CW'(cnt));
              state_next   = S_WRITE;
            end
          end
          K_FREE:  used_next = sat_sub(used, cnt);
          K_MARK:  used_next = sat_add(used, addn);
          default: ;
        endcase
      end

      S_WRITE: begin
        // Set the found run one bit per cycle
        wr_en    = 1'b1;
        wr_bit   = 1'b1;
        wr_addr  = ptr[IW-1:0];
        ptr_next = ptr + LW'(1);
        if (ptr + LW'(1) == end_ptr) begin
          res_next.frame_address = frame_addr(base_address, start[IW-1:0]);
          used_next  = sat_add(used, CW'(cnt));
          state_next = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
    res_next.used_frames = CNT_W'(used_next);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
      pend  <= 1'b0;
      qfill <= '0;
      qnext <= '0;
      used  <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      pend  <= pend_next;
      qfill <= qfill_next;
      qnext <= qnext_next;
      used  <= used_next;
    end
  end

  // Working registers and payload
  always_ff @(posedge clk) begin
    kind    <= kind_next;
    got     <= got_next;
    need    <= need_next;
    end_ptr <= end_ptr_next;
    pidx    <= pidx_next;
    start   <= start_next;
    serve   <= serve_next;
    found   <= found_next;
    first   <= first_next;
    run     <= run_next;
    cnt     <= cnt_next;
    addn    <= addn_next;
    res     <= res_next;
    if (q_we) begin
      queue[got[QI-1:0]] <= pidx[IW-1:0];
    end
  end

endmodule

@@ src/bfa_bitmap.sv @@
// Used-bit map storage: one write port, one registered read port
module bfa_bitmap #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit
);

  logic mem [DEPTH];

  // Write one bit, register one read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/bfa_checker.sv @@
// Port-level checker for the bitmap frame allocator, bound to the top level
`include "bitmap_frame_allocator_defines.svh"

module bfa_checker
  import bfa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `BFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a second command while busy")
  `BFA_ASSERT_NOW(a_no_accept_with_result, out_valid, in_stall, "input open while a result is pending")
  `BFA_ASSERT_NEXT(a_single_result, out_valid && !out_stall, !out_valid, "result transaction repeated")
  `BFA_ASSERT_NOW(a_status_code, out_valid, out_data.status <= ST_BAD_COUNT, "undefined status code")
  `BFA_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ test/bitmap_frame_allocator_test.sv @@
// Self-checking testbench for the bitmap frame allocator
`timescale 1ns / 1ps

class frame_map_scoreboard;
  localparam int NFR = 4096;
  localparam int QDEPTH = 16;
  localparam int SHIFT = 12;

  bit [31:0] base;
  bit [12:0] frames_cfg;
  bit used_bits [NFR];
  int unsigned queue_frames [QDEPTH];
  int unsigned fill;
  int unsigned next_slot;
  int unsigned used_cnt;
  bfa_pkg::out_t pending [$];
  int errors;

  function new();
    base = 0;
    frames_cfg = 13'd4096;
    foreach (used_bits[i]) used_bits[i] = 0;
    fill = 0;
    next_slot = 0;
    used_cnt = 0;
    errors = 0;
  endfunction

  function int unsigned frame_limit();
    return (frames_cfg > NFR) ? NFR : frames_cfg;
  endfunction

  function void count_up(longint unsigned n);
    longint unsigned v;
    v = used_cnt + n;
    used_cnt = (v > NFR) ? NFR : v;
  endfunction

  function bit [31:0] frame_byte_addr(int unsigned idx);
    return base + (idx << SHIFT);
  endfunction

  function int unsigned refill_queue(int unsigned n);
    int unsigned lim;
    int unsigned got;
    lim = frame_limit();
    got = 0;
    if (n > QDEPTH) n = QDEPTH;
    for (int unsigned i = 0; i < lim && got < n; i++) begin
      if (!used_bits[i]) begin
        used_bits[i] = 1;
        queue_frames[got] = i;
        got++;
      end
    end
    fill = got;
    next_slot = 0;
    return got;
  endfunction

  function void write_reg(bfa_pkg::reg_idx_t idx, bit [31:0] value);
    if (idx == bfa_pkg::REG_BASE_ADDRESS) base = value;
    else frames_cfg = value[12:0];
  endfunction

  // Predict the result of one accepted command transaction
  function void note_command(bfa_pkg::in_t item);
    bfa_pkg::out_t res;
    bit [2:0] op;
    int unsigned lim;
    int unsigned cnt;
    int unsigned run;
    int unsigned start;
    int unsigned s;
    int unsigned e;
    bit found;
    bit ok;
    res = '0;
    op = item.cmd;
    lim = frame_limit();
    cnt = item.count;
    if (op == bfa_pkg::CMD_ALLOC_RUN && cnt == 1) op = bfa_pkg::CMD_ALLOC_ONE;
    case (op)
      bfa_pkg::CMD_ALLOC_ONE: begin
        ok = 1;
        if (next_slot >= fill) begin
          if (refill_queue(QDEPTH) == 0) ok = 0;
          else res.applied = 1;
        end
        if (ok && next_slot < fill) begin
          res.frame_address = frame_byte_addr(queue_frames[next_slot]);
          next_slot++;
          count_up(1);
        end else begin
          res.status = bfa_pkg::ST_OUT_OF_MEM;
        end
      end
      bfa_pkg::CMD_ALLOC_RUN: begin
        if (cnt == 0) begin
          res.status = bfa_pkg::ST_BAD_COUNT;
        end else begin
          run = 0;
          found = 0;
          start = 0;
          for (int unsigned i = 0; i < lim; i++) begin
            run = used_bits[i] ? 0 : run + 1;
            if (run == cnt) begin
              start = i + 1 - cnt;
              found = 1;
              break;
            end
          end
          if (!found) begin
            res.status = bfa_pkg::ST_OUT_OF_MEM;
          end else begin
            for (int unsigned i = start; i < start + cnt; i++) used_bits[i] = 1;
            res.applied = 1;
            res.frame_address = frame_byte_addr(start);
            count_up(cnt);
          end
        end
      end
      bfa_pkg::CMD_FREE_RUN: begin
        if (cnt == 0) begin
          res.status = bfa_pkg::ST_BAD_COUNT;
        end else begin
          s = (item.address - base) >> SHIFT;
          if (longint'(s) + cnt > lim) begin
            res.status = bfa_pkg::ST_OUT_OF_RANGE;
          end else begin
            if (item.address[SHIFT-1:0] != 0) res.status = bfa_pkg::ST_MISALIGNED;
            else if (!used_bits[s]) res.status = bfa_pkg::ST_DOUBLE_FREE;
            for (int unsigned i = s; i < s + cnt; i++) begin
              if (used_bits[i]) res.applied = 1;
              used_bits[i] = 0;
            end
            used_cnt = (cnt > used_cnt) ? 0 : used_cnt - cnt;
          end
        end
      end
      bfa_pkg::CMD_MARK_USED: begin
        if ((item.address & bfa_pkg::MARK_ALIGN_MASK) != 0 ||
            (item.end_address & bfa_pkg::MARK_ALIGN_MASK) != 0) begin
          res.status = bfa_pkg::ST_MISALIGNED;
        end else begin
          s = (item.address - base) >> SHIFT;
          e = (item.end_address - base) >> SHIFT;
          if (e >= lim) begin
            res.status = bfa_pkg::ST_OUT_OF_RANGE;
          end else if (s <= e) begin
            for (int unsigned i = s; i <= e; i++) begin
              if (!used_bits[i]) res.applied = 1;
              used_bits[i] = 1;
            end
            count_up(e - s + 1);
          end
        end
      end
      bfa_pkg::CMD_PREFETCH: begin
        if (cnt == 0) res.status = bfa_pkg::ST_BAD_COUNT;
        else if (refill_queue(cnt) == 0) res.status = bfa_pkg::ST_OUT_OF_MEM;
        else res.applied = 1;
      end
      default: res.status = bfa_pkg::ST_OUT_OF_RANGE;
    endcase
    res.used_frames = used_cnt;
    pending.push_back(res);
  endfunction

  // Compare one result transaction with the oldest prediction
  function void check_result(bfa_pkg::out_t got);
    bfa_pkg::out_t want;
    if (pending.size() == 0) begin
      $error("result with no prediction pending");
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.applied !== want.applied) begin
      $error("applied: expected %0d, actual %0d", want.applied, got.applied);
      errors++;
    end
    if (got.frame_address !== want.frame_address) begin
      $error("frame_address: expected %h, actual %h", want.frame_address,
             got.frame_address);
      errors++;
    end
    if (got.used_frames !== want.used_frames) begin
      $error("used_frames: expected %0d, actual %0d", want.used_frames,
             got.used_frames);
      errors++;
    end
  endfunction
endclass

module bitmap_frame_allocator_test;
  import bfa_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [ADDR_W-1:0] cfg_data;

  frame_map_scoreboard board;
  bit quiet_tail;
  int phase_frames;

  bitmap_frame_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #40000000;
    $display("bitmap_frame_allocator_test NOT OK");
    $finish;
  end

  // Accept results, with random stall bursts until the quiet tail
  initial begin
    int burst;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_stall = 1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall = 1;
      end else begin
        out_stall = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
  end

  task automatic write_config(reg_idx_t idx, logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Send one command transaction, with an optional random gap first
  task automatic send_command(in_t item);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_data <= item;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_command(item);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [2:0] op, logic [31:0] a, logic [31:0] ea,
                             logic [12:0] n);
    in_t item;
    item.cmd = op;
    item.address = a;
    item.end_address = ea;
    item.count = n;
    send_command(item);
  endtask

  // Wait until no result is pending, then let the block settle
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (phase_frames + 40) @(negedge clk);
  endtask

  // Mostly small counts near used frames, some noise and big values
  task automatic random_command();
    logic [2:0] op;
    logic [31:0] a;
    logic [31:0] ea;
    logic [12:0] n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) op = CMD_ALLOC_ONE;
    else if (r < 48) op = CMD_ALLOC_RUN;
    else if (r < 75) op = CMD_FREE_RUN;
    else if (r < 87) op = CMD_MARK_USED;
    else if (r < 96) op = CMD_PREFETCH;
    else op = $urandom_range(5, 7);
    a = board.base + ($urandom_range(0, phase_frames + 2) << 12);
    ea = a + ($urandom_range(0, 20) << 12);
    if ($urandom_range(0, 9) == 0) a = $urandom;
    if ($urandom_range(0, 9) == 0) ea = $urandom;
    if ($urandom_range(0, 9) == 0) a[3:0] = $urandom;
    n = $urandom_range(0, 10) == 0 ? $urandom : $urandom_range(1, 24);
    if ($urandom_range(0, 29) == 0) n = 0;
    send_fields(op, a, ea, n);
  endtask

  initial begin
    int settings [4];
    board = new();
    quiet_tail = 0;
    phase_frames = 4096;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = REG_BASE_ADDRESS;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    repeat (4200) @(negedge clk);

    // Directed: extremes, every operation, warnings and rejects
    write_config(REG_FRAMES_IN_USE, 32'd40);
    phase_frames = 40;
    write_config(REG_BASE_ADDRESS, 32'hFFFF_F000);
    send_fields(CMD_ALLOC_ONE, '0, '0, 0);
    send_fields(CMD_ALLOC_RUN, '0, '0, 1);
    send_fields(CMD_ALLOC_RUN, '0, '0, 5);
    send_fields(CMD_ALLOC_RUN, '0, '0, 0);
    send_fields(CMD_ALLOC_RUN, '0, '0, 13'h1FFF);
    send_fields(CMD_FREE_RUN, 32'hFFFF_F000, '0, 1);
    send_fields(CMD_FREE_RUN, 32'hFFFF_F000, '0, 1);
    send_fields(CMD_FREE_RUN, 32'hFFFF_F001, '0, 2);
    send_fields(CMD_FREE_RUN, 32'hFFFF_F000, '0, 41);
    send_fields(CMD_FREE_RUN, 32'hFFFF_FFFF, '0, 0);
    send_fields(CMD_MARK_USED, 32'h0000_3000, 32'h0000_8000, 0);
    send_fields(CMD_MARK_USED, 32'h0000_3400, 32'h0000_8000, 0);
    send_fields(CMD_MARK_USED, 32'h0000_3000, 32'h0000_8001, 0);
    send_fields(CMD_MARK_USED, 32'h0000_9000, 32'h0000_3000, 0);
    send_fields(CMD_MARK_USED, 32'h0000_0000, 32'hFFFF_FC00, 0);
    send_fields(CMD_PREFETCH, '0, '0, 0);
    send_fields(CMD_PREFETCH, '0, '0, 3);
    send_fields(CMD_PREFETCH, '0, '0, 13'h1FFF);
    send_fields(3'd5, '1, '1, '1);
    send_fields(3'd7, '0, '0, 0);
    send_fields(CMD_MARK_USED, 32'hFFFF_F000, 32'h0002_6000, 0);
    send_fields(CMD_ALLOC_ONE, '0, '0, 0);
    send_fields(CMD_ALLOC_RUN, '0, '0, 2);
    send_fields(CMD_PREFETCH, '0, '0, 1);
    drain();

    // Random phases over several map sizes, ending with the full map
    settings = '{1, 64, 200, 4096};
    for (int p = 0; p < 4; p++) begin
      write_config(REG_FRAMES_IN_USE, settings[p] == 4096 ? 13'h1FFF : settings[p]);
      phase_frames = settings[p];
      write_config(REG_BASE_ADDRESS, p == 0 ? 32'h0 : $urandom);
      for (int k = 0; k < 125; k++) begin
        if (p == 3 && k > 100) quiet_tail = 1;
        random_command();
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("bitmap_frame_allocator_test OK");
    end else begin
      $display("bitmap_frame_allocator_test NOT OK");
    end
    $finish;
  end
endmodule
